@@ design/nsfe_pkg.sv @@
// Package for the sentence speed field extractor.
// Holds character codes, default sizes, the configuration reset value and the result type.
// No dependencies.
package nsfe_pkg;

   // Default sizes of the line and field windows
   localparam int LINE_MAX_DEFAULT  = 127;
   localparam int FIELD_MAX_DEFAULT = 15;

   // Widths of the fixed fields
   localparam int RX_BYTE_W      = 8;
   localparam int FIELD_NUMBER_W = 4;
   localparam int SPEED_W        = 32;
   localparam int COMMA_COUNT_W  = 5;
   localparam int FRAC_DIGITS_W  = 2;

   // Reset value of the field number register
   localparam logic [FIELD_NUMBER_W-1:0] FIELD_NUMBER_RESET = 4'd7;

   // Character codes
   localparam logic [RX_BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [RX_BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [RX_BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [RX_BYTE_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [RX_BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [RX_BYTE_W-1:0] CHAR_NINE  = 8'h39;

   // Saturation limits
   localparam logic [SPEED_W-1:0]       VALUE_MAX       = 32'hFFFF_FFFF;
   localparam logic [COMMA_COUNT_W-1:0] COMMA_COUNT_MAX = 5'd31;

   // Fraction digit positions
   localparam logic [FRAC_DIGITS_W-1:0] FRAC_TENTHS     = 2'd0;
   localparam logic [FRAC_DIGITS_W-1:0] FRAC_HUNDREDTHS = 2'd1;
   localparam logic [FRAC_DIGITS_W-1:0] FRAC_ROUNDING   = 2'd2;
   localparam logic [FRAC_DIGITS_W-1:0] FRAC_DONE       = 2'd3;

   // One line result
   typedef struct packed {
      logic               saturated;
      logic               field_present;
      logic [SPEED_W-1:0] speed_centi;
   } nsfe_result_type;

endpackage

@@ design/nsfe_line_parser.sv @@
// Line state and on-the-fly decimal converter of the sentence speed field extractor.
// Updates the line state for one byte per step and presents the line result.
// Depends on nsfe_pkg.
module nsfe_line_parser #(
   parameter int LINE_MAX  = nsfe_pkg::LINE_MAX_DEFAULT,
   parameter int FIELD_MAX = nsfe_pkg::FIELD_MAX_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [nsfe_pkg::RX_BYTE_W-1:0]       rx_byte,
   input  logic [nsfe_pkg::FIELD_NUMBER_W-1:0]  field_number,
   output logic                                 emit,
   output nsfe_pkg::nsfe_result_type            result
);
   import nsfe_pkg::*;

   localparam int LINE_W  = $clog2(LINE_MAX + 1);
   localparam int FIELD_W = $clog2(FIELD_MAX + 1);
   localparam int SUM_W   = SPEED_W + 4;

   logic [LINE_W-1:0]        line_length_ff, line_length_in;
   logic [COMMA_COUNT_W-1:0] comma_count_ff, comma_count_in;
   logic [FIELD_W-1:0]       field_length_ff, field_length_in;
   logic [SPEED_W-1:0]       value_ff, value_in;
   logic                     after_point_ff, after_point_in;
   logic [FRAC_DIGITS_W-1:0] frac_digits_ff, frac_digits_in;
   logic                     number_ended_ff, number_ended_in;
   logic                     overflow_ff, overflow_in;

   logic               is_lf, is_cr, is_comma, is_point, is_digit;
   logic [3:0]         digit;
   logic [SUM_W-1:0]   acc_wide;
   logic [SUM_W-1:0]   sum;
   logic               sum_used;
   logic               in_field;

   // Classify the byte
   assign is_lf    = (rx_byte == CHAR_LF);
   assign is_cr    = (rx_byte == CHAR_CR);
   assign is_comma = (rx_byte == CHAR_COMMA);
   assign is_point = (rx_byte == CHAR_POINT);
   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign digit    = 4'(rx_byte - CHAR_ZERO);
   assign acc_wide = {4'd0, value_ff};
   assign in_field = (comma_count_ff == {1'b0, field_number}) &&
                     (field_length_ff < FIELD_W'(FIELD_MAX));

   // Candidate new value for a digit at the current position
   always_comb begin
      sum      = acc_wide;
      sum_used = 1'b1;
      if (!after_point_ff) begin
         sum = (acc_wide << 3) + (acc_wide << 1) + (SUM_W'(digit) * SUM_W'(100));
      end else begin
         case (frac_digits_ff)
            FRAC_TENTHS:     sum = acc_wide + (SUM_W'(digit) * SUM_W'(10));
            FRAC_HUNDREDTHS: sum = acc_wide + SUM_W'(digit);
            FRAC_ROUNDING:   sum = acc_wide + SUM_W'(digit >= 4'd5);
            default:         sum_used = 1'b0;
         endcase
      end
   end

   // Next line state
   always_comb begin
      line_length_in  = line_length_ff;
      comma_count_in  = comma_count_ff;
      field_length_in = field_length_ff;
      value_in        = value_ff;
      after_point_in  = after_point_ff;
      frac_digits_in  = frac_digits_ff;
      number_ended_in = number_ended_ff;
      overflow_in     = overflow_ff;
      if (step) begin
         if (is_lf) begin
            line_length_in  = '0;
            comma_count_in  = '0;
            field_length_in = '0;
            value_in        = '0;
            after_point_in  = 1'b0;
            frac_digits_in  = FRAC_TENTHS;
            number_ended_in = 1'b0;
            overflow_in     = 1'b0;
         end else if (!is_cr && (line_length_ff < LINE_W'(LINE_MAX))) begin
            line_length_in = line_length_ff + LINE_W'(1);
            if (is_comma) begin
               if (comma_count_ff < COMMA_COUNT_MAX) begin
                  comma_count_in = comma_count_ff + COMMA_COUNT_W'(1);
               end
            end else if (in_field) begin
               field_length_in = field_length_ff + FIELD_W'(1);
               if (!number_ended_ff) begin
                  if (is_digit) begin
                     if (sum_used) begin
                        if (sum[SUM_W-1:SPEED_W] != '0) begin
                           value_in    = VALUE_MAX;
                           overflow_in = 1'b1;
                        end else begin
                           value_in = sum[SPEED_W-1:0];
                        end
                        if (after_point_ff) begin
                           frac_digits_in = frac_digits_ff + FRAC_DIGITS_W'(1);
                        end
                     end
                  end else if (is_point && !after_point_ff) begin
                     after_point_in = 1'b1;
                  end else begin
                     number_ended_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // Hold the line state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff  <= '0;
         comma_count_ff  <= '0;
         field_length_ff <= '0;
         value_ff        <= '0;
         after_point_ff  <= 1'b0;
         frac_digits_ff  <= FRAC_TENTHS;
         number_ended_ff <= 1'b0;
         overflow_ff     <= 1'b0;
      end else begin
         line_length_ff  <= line_length_in;
         comma_count_ff  <= comma_count_in;
         field_length_ff <= field_length_in;
         value_ff        <= value_in;
         after_point_ff  <= after_point_in;
         frac_digits_ff  <= frac_digits_in;
         number_ended_ff <= number_ended_in;
         overflow_ff     <= overflow_in;
      end
   end

   // Present the result of the line so far
   assign emit                 = step && is_lf;
   assign result.speed_centi   = value_ff;
   assign result.field_present = (comma_count_ff >= {1'b0, field_number});
   assign result.saturated     = overflow_ff;

   // A saturated value sits at the maximum
   a_sat_at_max: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (value_ff == VALUE_MAX))
      else $error("saturated value is not at maximum");

   // Fraction digits advance only after the point
   a_frac_after_point: assert property (@(posedge clock) disable iff (reset)
      !after_point_ff |-> (frac_digits_ff == FRAC_TENTHS))
      else $error("fraction digits counted before the point");

   // A line feed clears the line
   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> (line_length_ff == '0) && (comma_count_ff == '0) && !overflow_ff)
      else $error("line state not cleared after line feed");

endmodule

@@ design/nmea_speed_field_extractor_unit.sv @@
// Top level of the sentence speed field extractor: byte input register, line parser
// and result register with stream handshakes, plus the field number register.
// Depends on nsfe_pkg and nsfe_line_parser.
//
// Takes one received character per transfer on req_ and gives one result per line
// feed on rsp_: the selected field's value in hundredths, a field-present flag and a
// saturation flag. One character is accepted every cycle while results are taken; an
// accepted line feed is loaded into the input register, and the line state and
// converter update then move into the result register once that register is free.
// A stalled result holds up further characters only once the input register is full.
// The field number register is to be written by the user on csr_ only between lines;
// the block does not enforce it. It resets to 7.
module nmea_speed_field_extractor_unit #(
   parameter int LINE_MAX  = nsfe_pkg::LINE_MAX_DEFAULT,
   parameter int FIELD_MAX = nsfe_pkg::FIELD_MAX_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input characters
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] rx_byte
   // Line results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // [31:0] speed_centi
   output logic [1:0]                          rsp_tuser,  // [0] field_present, [1] saturated
   // Field number register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nsfe_pkg::FIELD_NUMBER_W-1:0] csr_data
);
   import nsfe_pkg::*;

   logic                      byte_vld_ff, byte_vld_in;
   logic [RX_BYTE_W-1:0]      byte_ff, byte_in;
   logic [FIELD_NUMBER_W-1:0] field_number_ff, field_number_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   nsfe_result_type           rsp_data_ff, rsp_data_in;

   logic            out_free;
   logic            step;
   logic            emit;
   nsfe_result_type result;

   // Process the held byte when the result register can take a result
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign step       = byte_vld_ff && out_free;
   assign req_tready = !byte_vld_ff || step;
   assign csr_ready  = 1'b1;

   // Advance the input register
   always_comb begin
      byte_vld_in = byte_vld_ff;
      byte_in     = byte_ff;
      if (req_tready) begin
         byte_vld_in = req_tvalid;
         byte_in     = req_tdata;
      end
   end

   // Load the field number
   assign field_number_in = csr_valid ? csr_data : field_number_ff;

   // Load or drain the result register
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = result;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff     <= 1'b0;
         rsp_vld_ff      <= 1'b0;
         field_number_ff <= FIELD_NUMBER_RESET;
      end else begin
         byte_vld_ff     <= byte_vld_in;
         rsp_vld_ff      <= rsp_vld_in;
         field_number_ff <= field_number_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   nsfe_line_parser #(
      .LINE_MAX  (LINE_MAX),
      .FIELD_MAX (FIELD_MAX)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (byte_ff),
      .field_number (field_number_ff),
      .emit         (emit),
      .result       (result)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff.speed_centi;
   assign rsp_tuser  = {rsp_data_ff.saturated, rsp_data_ff.field_present};

   // A processed line feed shows up as a result next cycle
   a_lf_to_result: assert property (@(posedge clock) disable iff (reset)
      (step && (byte_ff == CHAR_LF)) |=> rsp_tvalid)
      else $error("line feed did not produce a result");

   // Input stalls only when a byte waits behind a full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (byte_vld_ff && rsp_vld_ff && !rsp_tready))
      else $error("input stalled without cause");

   // A result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_tready) |-> !emit)
      else $error("pending result overwritten");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for nmea_speed_field_extractor_unit: streams sentence
// characters, predicts each line result in a scoreboard class and compares them.
// Depends on nsfe_pkg and the block's RTL.
module tb;
   import nsfe_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RANDOM_CHARS    = 1400;
   localparam int PHASE_COUNT     = 8;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_ALL_SET = 8'hFF;

   // Line-by-line speed predictor and store of expected line results
   class speed_scoreboard;
      logic [FIELD_NUMBER_W-1:0] field_sel;
      int unsigned               line_len;
      int unsigned               commas;
      int unsigned               fld_len;
      logic [SPEED_W-1:0]        acc;
      bit                        after_pt;
      bit                        ended;
      bit                        ovf;
      logic [FRAC_DIGITS_W-1:0]  frac;
      nsfe_result_type           line_results[$];
      int                        errors;

      function new();
         field_sel = FIELD_NUMBER_RESET;
         errors    = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_len = 0;
         commas   = 0;
         fld_len  = 0;
         acc      = '0;
         after_pt = 1'b0;
         ended    = 1'b0;
         ovf      = 1'b0;
         frac     = FRAC_TENTHS;
      endfunction

      // Clamp to the output range and remember the overflow
      function void put_value(longint unsigned v);
         if (v > VALUE_MAX) begin
            acc = VALUE_MAX;
            ovf = 1'b1;
         end else begin
            acc = v[SPEED_W-1:0];
         end
      endfunction

      // Feed one field character to the decimal converter
      function void convert(logic [7:0] c);
         longint unsigned d;
         if (ended)
            return;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            if (!after_pt) begin
               put_value(longint'(acc) * 10 + d * 100);
            end else begin
               case (frac)
                  FRAC_TENTHS: begin
                     put_value(longint'(acc) + d * 10);
                     frac = FRAC_HUNDREDTHS;
                  end
                  FRAC_HUNDREDTHS: begin
                     put_value(longint'(acc) + d);
                     frac = FRAC_ROUNDING;
                  end
                  FRAC_ROUNDING: begin
                     put_value(longint'(acc) + ((d >= 5) ? 1 : 0));
                     frac = FRAC_DONE;
                  end
                  default: ;
               endcase
            end
         end else if (c == CHAR_POINT && !after_pt) begin
            after_pt = 1'b1;
         end else begin
            ended = 1'b1;
         end
      endfunction

      // Note one accepted character; a line feed queues the line's result
      function void note_char(logic [7:0] c);
         nsfe_result_type r;
         if (c == CHAR_LF) begin
            r.speed_centi   = acc;
            r.field_present = (commas >= field_sel);
            r.saturated     = ovf;
            line_results.push_back(r);
            clear_line();
            return;
         end
         if (c == CHAR_CR)
            return;
         if (line_len >= LINE_MAX_DEFAULT)
            return;
         line_len++;
         if (c == CHAR_COMMA) begin
            if (commas < COMMA_COUNT_MAX)
               commas++;
            return;
         end
         if (commas == field_sel && fld_len < FIELD_MAX_DEFAULT) begin
            fld_len++;
            convert(c);
         end
      endfunction

      // Compare one accepted result with the oldest pending line
      function void check_line_result(logic [31:0] speed, logic present, logic sat);
         nsfe_result_type want;
         if (line_results.size() == 0) begin
            $display("%0t: result with no line pending: speed %0d present %0b saturated %0b",
                     $time, speed, present, sat);
            errors++;
            return;
         end
         want = line_results.pop_front();
         if (speed !== want.speed_centi) begin
            $display("%0t: speed_centi expected %0d actual %0d", $time, want.speed_centi, speed);
            errors++;
         end
         if (present !== want.field_present) begin
            $display("%0t: field_present expected %0b actual %0b",
                     $time, want.field_present, present);
            errors++;
         end
         if (sat !== want.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time, want.saturated, sat);
            errors++;
         end
      endfunction

      function int pending();
         return line_results.size();
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [31:0]               rsp_tdata;
   logic [1:0]                rsp_tuser;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [FIELD_NUMBER_W-1:0] csr_data   = '0;

   speed_scoreboard sb = new();
   bit              tx_quiet     = 1'b0;
   bit              rx_quiet     = 1'b0;
   bit              hold_off_req = 1'b0;
   int              chars_sent   = 0;
   int              idle_cycles  = 0;
   logic [7:0]      line_buf[$];

   nmea_speed_field_extractor_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watch every transfer: check results first, then note new characters
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_line_result(rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
         if (req_tvalid && req_tready)
            sb.note_char(req_tdata);
      end
   end

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("nmea_speed_field_extractor_unit: mismatch");
         $finish;
      end
   end

   // Result receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      wait (!reset);
      forever begin
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         stall = rx_quiet ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offer one character after a random gap and hold it until the transfer
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   // Stop sending and wait until every pending line result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_field_number(input logic [FIELD_NUMBER_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.field_sel = v;
   endtask

   function automatic logic [7:0] pick_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_filler();
      if ($urandom_range(0, 1) == 0)
         return pick_digit();
      return CHAR_UPPER_A + 8'($urandom_range(0, 25));
   endfunction

   // Number text for the selected field; a broken one carries a stray character
   function automatic void add_number(bit broken);
      string junk;
      int    n_int;
      junk  = "-+ .eE/A";
      n_int = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 4);
      repeat (n_int) line_buf.push_back(pick_digit());
      if (broken) begin
         line_buf.push_back(($urandom_range(0, 4) == 0) ? CHAR_NUL :
                            8'(junk[$urandom_range(0, 7)]));
         repeat ($urandom_range(0, 3)) line_buf.push_back(pick_digit());
      end
      if ($urandom_range(0, 3) != 0) begin
         line_buf.push_back(CHAR_POINT);
         repeat ($urandom_range(0, 5)) line_buf.push_back(pick_digit());
      end
   endfunction

   // Build one line: mostly well-formed sentences, some noise and overlong lines
   function automatic void build_line();
      int kind;
      int n_fields;
      line_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 40)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 13) begin
         repeat ($urandom_range(120, 170))
            line_buf.push_back(($urandom_range(0, 3) == 0) ? CHAR_COMMA : pick_filler());
      end else begin
         n_fields = ($urandom_range(0, 1) == 0) ? sb.field_sel + $urandom_range(0, 2)
                                                : $urandom_range(0, 17);
         for (int i = 0; i <= n_fields; i++) begin
            if (i > 0)
               line_buf.push_back(CHAR_COMMA);
            if (i == sb.field_sel)
               add_number(kind < 22);
            else
               repeat ($urandom_range(0, 3)) line_buf.push_back(pick_filler());
         end
      end
      if ($urandom_range(0, 3) == 0)
         line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
   endfunction

   initial begin
      int                        phase_end;
      logic [FIELD_NUMBER_W-1:0] sel;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines: reset field number first, then field 0 edge cases, then field 15
      send_text(",,,,,,,12.345\n");
      drain();
      write_field_number(4'd0);
      send_text("\n");
      send_text("0.005");
      send_char(CHAR_CR);
      send_text("\n4294967295.99\n-1\n1.2.3\n");
      send_char(CHAR_NUL);
      send_text("95\n");
      send_char(CHAR_ALL_SET);
      send_text("\n1");
      send_char(CHAR_CR);
      send_text("2\n000000000000001234\n");
      drain();
      write_field_number(4'd15);
      send_text(",,,,,,,,,,,,,,,99.9\n,,,\n");
      drain();

      // Random phases, each under its own field number and idling mode
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: sel = 4'd0;
            1: sel = 4'd15;
            6: sel = FIELD_NUMBER_RESET;
            default: sel = 4'($urandom_range(0, 15));
         endcase
         write_field_number(sel);
         tx_quiet = (p == 2) || (p == 4);
         rx_quiet = (p == 3);
         if (p == 4)
            hold_off_req = 1'b1;
         phase_end = chars_sent + RANDOM_CHARS / PHASE_COUNT;
         while (chars_sent < phase_end) begin
            build_line();
            foreach (line_buf[i])
               send_char(line_buf[i]);
            if ($urandom_range(0, 19) == 0)
               drain();
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending() == 0)
         $display("nmea_speed_field_extractor_unit: match");
      else
         $display("nmea_speed_field_extractor_unit: mismatch");
      $finish;
   end

endmodule
